[sv/xoodoo_permutation_defines.svh]
// Assertion macros shared by the Xoodoo permutation RTL.
// No dependencies; included by files that carry assertions.
`ifndef XOODOO_PERMUTATION_DEFINES_SVH
`define XOODOO_PERMUTATION_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define XOO_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset
`define XOO_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/xoo_pkg.sv]
// Types, constants and round function for the Xoodoo permutation.
// No dependencies; imported by xoo_stage, xoodoo_permutation and the testbench.
package xoo_pkg;

  localparam int MAX_ROUNDS = 12;
  localparam int ROUND_W    = 4;

  typedef logic [31:0] lane_t;
  // state[x][y]: column x (0..3), plane y (0..2)
  typedef logic [3:0][2:0][31:0] state_t;

  // Control traveling with each item through the pipeline
  typedef struct packed {
    logic               valid;
    logic [ROUND_W-1:0] first;  // first stage index that applies a round
  } stage_ctl_t;

  function automatic lane_t rotl(lane_t v, logic [4:0] s);
    lane_t r;
    r = (v << s) | (v >> (6'd32 - {1'b0, s}));
    return r;
  endfunction

  // Standard round constants, index 0..MAX_ROUNDS-1
  function automatic lane_t round_const(logic [ROUND_W-1:0] idx);
    lane_t c;
    case (idx)
      4'd0:    c = 32'h0000_0058;
      4'd1:    c = 32'h0000_0038;
      4'd2:    c = 32'h0000_03C0;
      4'd3:    c = 32'h0000_00D0;
      4'd4:    c = 32'h0000_0120;
      4'd5:    c = 32'h0000_0014;
      4'd6:    c = 32'h0000_0060;
      4'd7:    c = 32'h0000_002C;
      4'd8:    c = 32'h0000_0380;
      4'd9:    c = 32'h0000_00F0;
      4'd10:   c = 32'h0000_01A0;
      4'd11:   c = 32'h0000_0012;
      default: c = '0;
    endcase
    return c;
  endfunction

  // One full round: theta, rho-west, iota, chi, rho-east
  function automatic state_t xoo_round(state_t a, lane_t rc);
    lane_t  par [4];
    lane_t  eff [4];
    state_t t;
    state_t w;
    state_t b;
    state_t r;
    for (int x = 0; x < 4; x++) begin
      par[x] = a[x][0] ^ a[x][1] ^ a[x][2];
    end
    // theta: column parity of the western neighbor, folded twice
    for (int x = 0; x < 4; x++) begin
      eff[x] = rotl(par[(x + 3) & 3], 5'd5) ^ rotl(par[(x + 3) & 3], 5'd14);
    end
    for (int x = 0; x < 4; x++) begin
      for (int y = 0; y < 3; y++) begin
        t[x][y] = a[x][y] ^ eff[x];
      end
    end
    // rho-west
    for (int x = 0; x < 4; x++) begin
      w[x][0] = t[x][0];
      w[x][1] = t[(x + 3) & 3][1];
      w[x][2] = rotl(t[x][2], 5'd11);
    end
    // iota
    w[0][0] = w[0][0] ^ rc;
    // chi
    for (int x = 0; x < 4; x++) begin
      b[x][0] = w[x][0] ^ (~w[x][1] & w[x][2]);
      b[x][1] = w[x][1] ^ (~w[x][2] & w[x][0]);
      b[x][2] = w[x][2] ^ (~w[x][0] & w[x][1]);
    end
    // rho-east
    for (int x = 0; x < 4; x++) begin
      r[x][0] = b[x][0];
      r[x][1] = rotl(b[x][1], 5'd1);
      r[x][2] = rotl(b[(x + 2) & 3][2], 5'd8);
    end
    return r;
  endfunction

endpackage

[sv/xoo_stage.sv]
// One pipeline stage: applies one Xoodoo round (or passes through) and registers it.
// Depends on xoo_pkg.
module xoo_stage import xoo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [ROUND_W-1:0] stage_idx,
  input  stage_ctl_t         up_ctl,
  input  state_t             up_state,
  output logic               up_ready,
  output stage_ctl_t         dn_ctl,
  output state_t             dn_state,
  input  logic               dn_ready
);

  logic   active;
  state_t state_next;

  // stage moves when empty or when the next one takes its item
  assign up_ready = !dn_ctl.valid || dn_ready;

  // rounds run only in the last round_count stages
  assign active     = (stage_idx >= up_ctl.first);
  assign state_next = active ? xoo_round(up_state, round_const(stage_idx)) : up_state;

  // payload needs no reset; only the valid bit is cleared
  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      dn_ctl.first <= up_ctl.first;
      dn_state     <= state_next;
    end
    if (rst) begin
      dn_ctl.valid <= 1'b0;
    end else if (up_ready) begin
      dn_ctl.valid <= up_ctl.valid;
    end
  end

endmodule

[sv/xoodoo_permutation.sv]
// Xoodoo permutation, 384-bit state, one round per pipeline stage, twelve stages.
// Every item passes through every stage register from input accept to output valid, whatever round_count is.
// Throughput: one item per cycle while out_ready is high; the last stage register is the output register.
// Reset (synchronous): empties the pipeline and sets round_count to 12.
// Depends on xoo_pkg, xoo_stage and xoodoo_permutation_defines.svh.
`include "xoodoo_permutation_defines.svh"
module xoodoo_permutation import xoo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_c0_p0,
  input  logic [31:0] in_c0_p1,
  input  logic [31:0] in_c0_p2,
  input  logic [31:0] in_c1_p0,
  input  logic [31:0] in_c1_p1,
  input  logic [31:0] in_c1_p2,
  input  logic [31:0] in_c2_p0,
  input  logic [31:0] in_c2_p1,
  input  logic [31:0] in_c2_p2,
  input  logic [31:0] in_c3_p0,
  input  logic [31:0] in_c3_p1,
  input  logic [31:0] in_c3_p2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_c0_p0,
  output logic [31:0] out_c0_p1,
  output logic [31:0] out_c0_p2,
  output logic [31:0] out_c1_p0,
  output logic [31:0] out_c1_p1,
  output logic [31:0] out_c1_p2,
  output logic [31:0] out_c2_p0,
  output logic [31:0] out_c2_p1,
  output logic [31:0] out_c2_p2,
  output logic [31:0] out_c3_p0,
  output logic [31:0] out_c3_p1,
  output logic [31:0] out_c3_p2
);

  logic [ROUND_W-1:0] round_count;
  logic [ROUND_W-1:0] round_count_next;
  logic [ROUND_W-1:0] first_idx;

  stage_ctl_t ctl [MAX_ROUNDS+1];
  state_t     st  [MAX_ROUNDS+1];
  logic       rdy [MAX_ROUNDS+1];
  logic [MAX_ROUNDS-1:0] stage_valid;

  // round count register, saturating into 1..12
  always_comb begin
    if (cfg_wdata == '0) begin
      round_count_next = ROUND_W'(1);
    end else if (cfg_wdata > ROUND_W'(MAX_ROUNDS)) begin
      round_count_next = ROUND_W'(MAX_ROUNDS);
    end else begin
      round_count_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= ROUND_W'(MAX_ROUNDS);
    end else if (cfg_we) begin
      round_count <= round_count_next;
    end
  end

  // last round_count constants are used
  assign first_idx = ROUND_W'(MAX_ROUNDS) - round_count;

  // pipeline input
  assign ctl[0].valid = in_valid;
  assign ctl[0].first = first_idx;
  assign st[0][0][0] = in_c0_p0;
  assign st[0][0][1] = in_c0_p1;
  assign st[0][0][2] = in_c0_p2;
  assign st[0][1][0] = in_c1_p0;
  assign st[0][1][1] = in_c1_p1;
  assign st[0][1][2] = in_c1_p2;
  assign st[0][2][0] = in_c2_p0;
  assign st[0][2][1] = in_c2_p1;
  assign st[0][2][2] = in_c2_p2;
  assign st[0][3][0] = in_c3_p0;
  assign st[0][3][1] = in_c3_p1;
  assign st[0][3][2] = in_c3_p2;
  assign in_ready    = rdy[0];

  // round stages
  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_stage
    xoo_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (ROUND_W'(i)),
      .up_ctl    (ctl[i]),
      .up_state  (st[i]),
      .up_ready  (rdy[i]),
      .dn_ctl    (ctl[i+1]),
      .dn_state  (st[i+1]),
      .dn_ready  (rdy[i+1])
    );
    assign stage_valid[i] = ctl[i+1].valid;
  end

  // pipeline output
  assign rdy[MAX_ROUNDS] = out_ready;
  assign out_valid = ctl[MAX_ROUNDS].valid;
  assign out_c0_p0 = st[MAX_ROUNDS][0][0];
  assign out_c0_p1 = st[MAX_ROUNDS][0][1];
  assign out_c0_p2 = st[MAX_ROUNDS][0][2];
  assign out_c1_p0 = st[MAX_ROUNDS][1][0];
  assign out_c1_p1 = st[MAX_ROUNDS][1][1];
  assign out_c1_p2 = st[MAX_ROUNDS][1][2];
  assign out_c2_p0 = st[MAX_ROUNDS][2][0];
  assign out_c2_p1 = st[MAX_ROUNDS][2][1];
  assign out_c2_p2 = st[MAX_ROUNDS][2][2];
  assign out_c3_p0 = st[MAX_ROUNDS][3][0];
  assign out_c3_p1 = st[MAX_ROUNDS][3][1];
  assign out_c3_p2 = st[MAX_ROUNDS][3][2];

  // checks
  `XOO_ASSERT_IMPL(a_rc_range, 1'b1, (round_count != '0) && (round_count <= ROUND_W'(MAX_ROUNDS)), "round_count out of range")
  `XOO_ASSERT_NEXT(a_first_tag, in_valid && in_ready, ctl[1].valid && (ctl[1].first == $past(first_idx)), "stage 0 lost item or round tag")
  `XOO_ASSERT_IMPL(a_full_stall, !in_ready, &stage_valid, "input stalled with a bubble in the pipeline")

endmodule

[verif/xoodoo_permutation_tb.sv]
// Self-checking testbench for the Xoodoo permutation pipeline (xoodoo_permutation).
// Directed table then randomized items under several idle/stall mixes, checked lane by lane.
// Depends on xoo_pkg and the xoodoo_permutation RTL.
`timescale 1ns / 100ps

module xoodoo_permutation_tb import xoo_pkg::*;;

  // state[x][y]: column x, plane y; same bit layout as the twelve lane ports
  typedef logic [3:0][2:0][31:0] grid_t;

  typedef struct packed {
    logic [3:0] rounds;
    grid_t      lanes;
  } dir_row_t;

  localparam int DIR_ROWS     = 20;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int HOLD_CYCLES  = 60;
  localparam int PIPE_LATENCY = 12;
  localparam int LIMIT_CYCLES = 200000;

  // Standard round constants, index 0 in the low word
  localparam logic [11:0][31:0] ROUND_CONSTS = {
    32'h0000_0012, 32'h0000_01A0, 32'h0000_00F0, 32'h0000_0380,
    32'h0000_002C, 32'h0000_0060, 32'h0000_0014, 32'h0000_0120,
    32'h0000_00D0, 32'h0000_03C0, 32'h0000_0038, 32'h0000_0058
  };

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  grid_t      in_st;
  logic       out_valid;
  logic       out_ready;
  wire [3:0][2:0][31:0] out_st;

  grid_t expected_q[$];
  grid_t want_st;
  int    cur_rounds;
  int    send_gap_pct;
  int    stall_pct;
  bit    hold_pending;
  int    mismatches;
  int    cycle_count;

  xoodoo_permutation i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_c0_p0  (in_st[0][0]),
    .in_c0_p1  (in_st[0][1]),
    .in_c0_p2  (in_st[0][2]),
    .in_c1_p0  (in_st[1][0]),
    .in_c1_p1  (in_st[1][1]),
    .in_c1_p2  (in_st[1][2]),
    .in_c2_p0  (in_st[2][0]),
    .in_c2_p1  (in_st[2][1]),
    .in_c2_p2  (in_st[2][2]),
    .in_c3_p0  (in_st[3][0]),
    .in_c3_p1  (in_st[3][1]),
    .in_c3_p2  (in_st[3][2]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_c0_p0 (out_st[0][0]),
    .out_c0_p1 (out_st[0][1]),
    .out_c0_p2 (out_st[0][2]),
    .out_c1_p0 (out_st[1][0]),
    .out_c1_p1 (out_st[1][1]),
    .out_c1_p2 (out_st[1][2]),
    .out_c2_p0 (out_st[2][0]),
    .out_c2_p1 (out_st[2][1]),
    .out_c2_p2 (out_st[2][2]),
    .out_c3_p0 (out_st[3][0]),
    .out_c3_p1 (out_st[3][1]),
    .out_c3_p2 (out_st[3][2])
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Xoodoo[nr]: theta, rho-west, iota, chi, rho-east per round
  function automatic grid_t xoodoo_rounds(grid_t a, int nr);
    grid_t            b;
    logic [3:0][31:0] par;
    logic [3:0][31:0] mix;
    for (int r = 0; r < nr; r++) begin
      for (int x = 0; x < 4; x++) begin
        par[x] = a[x][0] ^ a[x][1] ^ a[x][2];
      end
      for (int x = 0; x < 4; x++) begin
        mix[x] = rol32(par[(x + 3) % 4], 5) ^ rol32(par[(x + 3) % 4], 14);
      end
      for (int x = 0; x < 4; x++) begin
        for (int y = 0; y < 3; y++) begin
          a[x][y] = a[x][y] ^ mix[x];
        end
      end
      b = a;
      for (int x = 0; x < 4; x++) begin
        a[x][1] = b[(x + 3) % 4][1];
        a[x][2] = rol32(b[x][2], 11);
      end
      a[0][0] = a[0][0] ^ ROUND_CONSTS[MAX_ROUNDS - nr + r];
      for (int x = 0; x < 4; x++) begin
        for (int y = 0; y < 3; y++) begin
          b[x][y] = a[x][y] ^ (~a[x][(y + 1) % 3] & a[x][(y + 2) % 3]);
        end
      end
      for (int x = 0; x < 4; x++) begin
        a[x][0] = b[x][0];
        a[x][1] = rol32(b[x][1], 1);
        a[x][2] = rol32(b[(x + 2) % 4][2], 8);
      end
    end
    return a;
  endfunction

  // Directed stimulus: round count to program, then the input state
  function automatic dir_row_t dir_row(int i);
    dir_row_t r;
    case (i)
      0:       r = '{4'd12, '0};
      1:       r = '{4'd12, '1};
      2:       r = '{4'd12, 384'h1};
      3:       r = '{4'd12, {1'b1, 383'h0}};
      4:       r = '{4'd12, {12{32'hAAAA_AAAA}}};
      5:       r = '{4'd12, {12{32'h5555_5555}}};
      6:       r = '{4'd12, {6{32'hFFFF_FFFF, 32'h0000_0000}}};
      7:       r = '{4'd12, {12{32'h8000_0001}}};
      8:       r = '{4'd1, '0};
      9:       r = '{4'd1, '1};
      10:      r = '{4'd1, 384'h1};
      11:      r = '{4'd1, {12{32'hDEAD_BEEF}}};
      // zero round count saturates to one round
      12:      r = '{4'd0, '0};
      13:      r = '{4'd0, '1};
      // counts above twelve saturate to twelve
      14:      r = '{4'd15, '0};
      15:      r = '{4'd15, {12{32'h0F0F_F0F0}}};
      16:      r = '{4'd13, '1};
      17:      r = '{4'd6, '0};
      18:      r = '{4'd6, {4{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678}}};
      default: r = '{4'd12, '0};
    endcase
    return r;
  endfunction

  // Mostly dense random states, some sparse or saturated lanes
  function automatic grid_t random_state();
    grid_t        s;
    int           kind;
    logic [383:0] flat;
    logic [8:0]   pos;
    kind = $urandom_range(0, 9);
    for (int x = 0; x < 4; x++) begin
      for (int y = 0; y < 3; y++) begin
        s[x][y] = $urandom;
        if (kind == 2) begin
          case ($urandom_range(0, 2))
            0:       s[x][y] = '0;
            1:       s[x][y] = '1;
            default: s[x][y] = $urandom;
          endcase
        end
      end
    end
    pos = 9'($urandom_range(0, 383));
    // single set bit, or single clear bit, anywhere in the 384-bit state
    if (kind == 0) begin
      flat      = '0;
      flat[pos] = 1'b1;
      s         = flat;
    end else if (kind == 1) begin
      flat      = '1;
      flat[pos] = 1'b0;
      s         = flat;
    end
    return s;
  endfunction

  // Offer one item, with random idle cycles ahead of it
  task automatic send_item(grid_t v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_st    <= v;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Program the round count while the pipeline is empty
  task automatic write_rounds(logic [3:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (v == 4'd0) begin
      cur_rounds = 1;
    end else if (v > MAX_ROUNDS) begin
      cur_rounds = MAX_ROUNDS;
    end else begin
      cur_rounds = v;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_pending = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Predict on input accept, compare on output accept
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(xoodoo_rounds(in_st, cur_rounds));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected output item: %h", out_st);
          mismatches++;
        end else begin
          want_st = expected_q.pop_front();
          for (int x = 0; x < 4; x++) begin
            for (int y = 0; y < 3; y++) begin
              if (out_st[x][y] !== want_st[x][y]) begin
                $error("out_c%0d_p%0d: expected %h, actual %h",
                       x, y, want_st[x][y], out_st[x][y]);
                mismatches++;
              end
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    logic [3:0] last_written;
    logic [3:0] phase_rounds;

    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_st        = '0;
    cur_rounds   = MAX_ROUNDS;
    send_gap_pct = 30;
    stall_pct    = 30;
    hold_pending = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    last_written = 4'd12;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; round count is reprogrammed when a row asks for a new one
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      if (row.rounds != last_written) begin
        write_rounds(row.rounds);
        last_written = row.rounds;
      end
      send_item(row.lanes);
    end

    // Random phases: each picks a round count and an idle/stall mix
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       phase_rounds = 4'd1;
        1:       phase_rounds = 4'd12;
        2:       phase_rounds = 4'd0;
        3:       phase_rounds = 4'd15;
        default: phase_rounds = 4'($urandom_range(0, 15));
      endcase
      write_rounds(phase_rounds);
      case (ph % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 45;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 45;
        end
        default: begin
          send_gap_pct = 30;
          stall_pct    = 30;
        end
      endcase
      // long receiver hold-off while items keep coming: pipeline backs up
      if (ph == 0) begin
        hold_pending = 1'b1;
      end
      repeat (PHASE_ITEMS) send_item(random_state());
    end

    drain();
    repeat (PIPE_LATENCY + 8) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d output items never arrived", expected_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
